>>> design/stcr_pkg.sv
// Package: item types and constants for the stick to camera remapper.
`default_nettype none

package stcr_pkg;

    typedef struct packed {
        logic [31:0] now_time;
        logic [31:0] buttons_in;
        logic [7:0]  left_x_in;
        logic [7:0]  left_y_in;
        logic [7:0]  right_x_in;
        logic [7:0]  right_y_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] buttons_out;
        logic [7:0]  left_x_out;
        logic [7:0]  left_y_out;
        logic [7:0]  right_x_out;
        logic [7:0]  right_y_out;
    } t_out_item;

    localparam int unsigned CFG_DATA_W = 31;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned MAP_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MASK_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MASK_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DELAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_RIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LEFT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_UP         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_DOWN       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE       = 3'd7;

    localparam logic signed [MAP_W-1:0] MAP_SRC_UP    = -17'sd1;
    localparam logic signed [MAP_W-1:0] MAP_SRC_DOWN  = -17'sd2;
    localparam logic signed [MAP_W-1:0] MAP_SRC_LEFT  = -17'sd3;
    localparam logic signed [MAP_W-1:0] MAP_SRC_RIGHT = -17'sd4;

    localparam logic [7:0] CENTRE       = 8'd127;
    localparam logic [7:0] FULL         = 8'd255;
    localparam logic [6:0] DEADZONE_RST = 7'd32;

endpackage

`default_nettype wire

>>> design/stick_to_camera_remapper_top.sv
// Top level: right stick to camera remapper, one sample per unstalled cycle.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_item carries one gamepad
//   sample with its timestamp; an item is taken at an edge where valid is
//   high and stall is low. Output channel o_out_valid / i_out_stall /
//   o_out_item returns one result item per sample, in order.
//   Each sample passes the input register, then the result register.
//   Throughput: one item per cycle while the receiver does not stall.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (trigger masks, move delay, four direction maps, deadzone); the user
//   must write only while idle, and the block does not enforce it.
//   Reset: both stages empty, last centred time zero, registers at their
//   reset values (deadzone 32, others zero).
//   Receiver stall: the result register holds; the input register holds
//   when it cannot move forward, and then o_in_stall rises.
`default_nettype none

module stick_to_camera_remapper_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  stcr_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output stcr_pkg::t_out_item                   o_out_item,
    input  wire                                   i_cfg_we,
    input  wire  [stcr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [stcr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [15:0]                         r_mask_a;
    logic [15:0]                         r_mask_b;
    logic [30:0]                         r_move_delay;
    logic signed [stcr_pkg::MAP_W-1:0]   r_map_right;
    logic signed [stcr_pkg::MAP_W-1:0]   r_map_left;
    logic signed [stcr_pkg::MAP_W-1:0]   r_map_up;
    logic signed [stcr_pkg::MAP_W-1:0]   r_map_down;
    logic [6:0]                          r_deadzone;

    logic                 r_s1_valid;
    stcr_pkg::t_in_item   r_s1_item;
    logic                 r_out_valid;
    stcr_pkg::t_out_item  r_out_item;
    logic [31:0]          r_last;

    logic                 w_out_ready;
    logic                 w_s1_ready;
    logic                 w_s2_load;

    logic [7:0]           w_rx;
    logic [7:0]           w_ry;
    logic [7:0]           w_hi;
    logic [7:0]           w_lo;
    logic                 w_centred;
    logic                 w_deflected;
    logic [31:0]          w_last_eff;
    logic [31:0]          w_target;
    logic                 w_delay_ok;
    logic [31:0]          n_last;
    stcr_pkg::t_out_item  n_out_item;

    function automatic logic f_is_mask(input logic signed [stcr_pkg::MAP_W-1:0] map);
        f_is_mask = !map[stcr_pkg::MAP_W-1] && (map != '0);
    endfunction

    function automatic logic [7:0] f_axis(
        input logic signed [stcr_pkg::MAP_W-1:0] map,
        input logic                              inv,
        input logic [7:0]                        rx,
        input logic [7:0]                        ry,
        input logic [7:0]                        lo,
        input logic [7:0]                        hi,
        input logic [7:0]                        axis
    );
        logic [7:0] res;
        res = axis;
        unique case (map)
            stcr_pkg::MAP_SRC_UP: begin
                if (ry <= lo) res = inv ? ry : stcr_pkg::FULL - ry;
            end
            stcr_pkg::MAP_SRC_DOWN: begin
                if (ry >= hi) res = inv ? stcr_pkg::FULL - ry : ry;
            end
            stcr_pkg::MAP_SRC_LEFT: begin
                if (rx <= lo) res = inv ? rx : stcr_pkg::FULL - rx;
            end
            stcr_pkg::MAP_SRC_RIGHT: begin
                if (rx >= hi) res = inv ? stcr_pkg::FULL - rx : rx;
            end
            default: begin
                res = axis;
            end
        endcase
        f_axis = res;
    endfunction

    function automatic logic [31:0] f_btn(
        input logic signed [stcr_pkg::MAP_W-1:0] map,
        input logic                              cond
    );
        f_btn = (f_is_mask(map) && cond) ? {16'h0000, map[15:0]} : 32'h0000_0000;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_a     <= '0;
            r_mask_b     <= '0;
            r_move_delay <= '0;
            r_map_right  <= '0;
            r_map_left   <= '0;
            r_map_up     <= '0;
            r_map_down   <= '0;
            r_deadzone   <= stcr_pkg::DEADZONE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                stcr_pkg::CFG_TRIGGER_MASK_A: r_mask_a     <= i_cfg_data[15:0];
                stcr_pkg::CFG_TRIGGER_MASK_B: r_mask_b     <= i_cfg_data[15:0];
                stcr_pkg::CFG_MOVE_DELAY:     r_move_delay <= i_cfg_data[30:0];
                stcr_pkg::CFG_MAP_RIGHT:      r_map_right  <= i_cfg_data[16:0];
                stcr_pkg::CFG_MAP_LEFT:       r_map_left   <= i_cfg_data[16:0];
                stcr_pkg::CFG_MAP_UP:         r_map_up     <= i_cfg_data[16:0];
                stcr_pkg::CFG_MAP_DOWN:       r_map_down   <= i_cfg_data[16:0];
                stcr_pkg::CFG_DEADZONE:       r_deadzone   <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_s1_ready  = !r_s1_valid || w_out_ready;
    assign w_s2_load   = r_s1_valid && w_out_ready;
    assign o_in_stall  = !w_s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    // Remap logic
    assign w_rx        = r_s1_item.right_x_in;
    assign w_ry        = r_s1_item.right_y_in;
    assign w_hi        = stcr_pkg::CENTRE + {1'b0, r_deadzone};
    assign w_lo        = stcr_pkg::CENTRE - {1'b0, r_deadzone};
    assign w_centred   = (w_rx <= w_hi) && (w_rx > w_lo) && (w_ry <= w_hi) && (w_ry > w_lo);
    assign w_deflected = (w_rx >= w_hi) || (w_rx < w_lo) || (w_ry >= w_hi) || (w_ry < w_lo);
    assign w_last_eff  = w_centred ? r_s1_item.now_time : r_last;
    assign w_target    = w_last_eff + {1'b0, r_move_delay};
    assign w_delay_ok  = r_s1_item.now_time >= w_target;
    assign n_last      = w_last_eff;

    always_comb begin
        n_out_item.buttons_out = r_s1_item.buttons_in;
        n_out_item.left_x_out  = r_s1_item.left_x_in;
        n_out_item.left_y_out  = r_s1_item.left_y_in;
        n_out_item.right_x_out = stcr_pkg::CENTRE;
        n_out_item.right_y_out = stcr_pkg::CENTRE;
        if (w_deflected) begin
            n_out_item.buttons_out = n_out_item.buttons_out | {16'h0000, r_mask_a | r_mask_b};
            if (w_delay_ok) begin
                n_out_item.buttons_out = n_out_item.buttons_out
                    | f_btn(r_map_right, w_rx >= w_hi)
                    | f_btn(r_map_left,  w_rx <= w_lo)
                    | f_btn(r_map_up,    w_ry <= w_lo)
                    | f_btn(r_map_down,  w_ry >= w_hi);
                n_out_item.left_x_out = f_axis(r_map_right, 1'b0, w_rx, w_ry, w_lo, w_hi,
                                               n_out_item.left_x_out);
                n_out_item.left_x_out = f_axis(r_map_left, 1'b1, w_rx, w_ry, w_lo, w_hi,
                                               n_out_item.left_x_out);
                n_out_item.left_y_out = f_axis(r_map_up, 1'b1, w_rx, w_ry, w_lo, w_hi,
                                               n_out_item.left_y_out);
                n_out_item.left_y_out = f_axis(r_map_down, 1'b0, w_rx, w_ry, w_lo, w_hi,
                                               n_out_item.left_y_out);
            end
        end
    end

    // Result register and centred time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            if (w_out_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_s2_load) begin
                r_last <= n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

`default_nettype wire
